// ===== hw/rtl/bnfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bnfa_pkg: shared types and constants
// Field widths, status codes, register indexes and the controller/datapath
// command and status bundles of the next-fit block allocator.
// ----------------------------------------------------------------------------
package bnfa_pkg;

    localparam int DEF_NUM_BLOCKS  = 4096;
    localparam int DEF_BLOCK_BYTES = 256;

    localparam int SIZE_W     = 21;     // byte_size, granted_bytes
    localparam int OFFS_W     = 20;     // byte_offset, granted_offset
    localparam int DIV_W      = 22;     // byte_size plus rounding term
    localparam int BC_W       = 13;     // block_count register
    localparam int FB_W       = 12;     // first_block register
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int WORD_BITS  = 8;      // map bits per RAM word
    localparam int WB_LOG     = 3;

    localparam logic [BC_W-1:0] BC_RESET = BC_W'(4096);
    localparam logic [SIZE_W-1:0] BYTES_MAX = {SIZE_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_ZERO     = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_COUNT = 1'b0,
        CFG_FIRST_BLOCK = 1'b1
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // clearing pass step
        logic load;     // latch request, start dividers
        logic decide;   // classify request
        logic restart;  // second search pass from first_block
        logic fail;     // search exhausted
        logic eval;     // evaluate one map word
        logic mwrite;   // write back one modified word
        logic finish;   // load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic go_search;
        logic go_modify;
        logic past_end;
        logic pass2;
        logic found;
        logic m_last;
    } t_dp_sts;

endpackage

// ===== hw/rtl/bnfa_req_if.sv =====
// ----------------------------------------------------------------------------
// bnfa_req_if: request channel
// Valid/ready channel carrying one allocate or free request per beat.
// ----------------------------------------------------------------------------
interface bnfa_req_if;
    import bnfa_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [SIZE_W-1:0] byte_size;
    logic [OFFS_W-1:0] byte_offset;

    modport source (output valid, output action, output byte_size, output byte_offset,
                    input ready);
    modport sink   (input valid, input action, input byte_size, input byte_offset,
                    output ready);
endinterface

// ===== hw/rtl/bnfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bnfa_rsp_if: response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface bnfa_rsp_if;
    import bnfa_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [OFFS_W-1:0] granted_offset;
    logic [SIZE_W-1:0] granted_bytes;

    modport source (output valid, output status, output granted_offset,
                    output granted_bytes, input ready);
    modport sink   (input valid, input status, input granted_offset,
                    input granted_bytes, output ready);
endinterface

// ===== hw/rtl/bnfa_ram.sv =====
// ----------------------------------------------------------------------------
// bnfa_ram: single-port RAM
// One address per cycle, write on enable, registered read of the same address.
// ----------------------------------------------------------------------------
module bnfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hw/rtl/bnfa_div.sv =====
// ----------------------------------------------------------------------------
// bnfa_div: divider by a constant
// Reciprocal multiply, quotient registered the cycle after start.
// ----------------------------------------------------------------------------
module bnfa_div #(
    parameter int DW      = 22,
    parameter int DIVISOR = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    output logic [DW-1:0] o_quotient,
    output logic          o_done
);
    localparam int SH = DW + $clog2(DIVISOR);
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

    logic          r_busy;
    logic [DW-1:0] r_quo;
    logic [PW-1:0] w_prod;

    // x / D == (x * ceil(2^SH / D)) >> SH for every x below 2^DW
    assign w_prod     = PW'(i_dividend) * PW'(RECIP);
    assign o_quotient = r_quo;
    assign o_done     = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DW'(w_prod >> SH);
        end
    end
endmodule

// ===== hw/rtl/bnfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bnfa_ctrl: allocator controller
// Sequences clearing, division, search, map update and result hand-off.
// ----------------------------------------------------------------------------
module bnfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bnfa_pkg::t_dp_cmd  o_cmd,
    input  bnfa_pkg::t_dp_sts  i_sts
);
    import bnfa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIVIDE, S_DECIDE, S_SREAD, S_SEVAL,
        S_MREAD, S_MWRITE, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (i_sts.div_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.go_search)      n_state = S_SREAD;
                else if (i_sts.go_modify) n_state = S_MREAD;
                else                      n_state = S_FINISH;
            end
            S_SREAD: begin
                if (i_sts.past_end) begin
                    if (i_sts.pass2) begin
                        o_cmd.fail = 1'b1;
                        n_state    = S_FINISH;
                    end else begin
                        o_cmd.restart = 1'b1;
                    end
                end else begin
                    n_state = S_SEVAL;
                end
            end
            S_SEVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.found ? S_MREAD : S_SREAD;
            end
            S_MREAD: begin
                n_state = S_MWRITE;
            end
            S_MWRITE: begin
                o_cmd.mwrite = 1'b1;
                n_state      = i_sts.m_last ? S_FINISH : S_MREAD;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== hw/rtl/bnfa_dp.sv =====
// ----------------------------------------------------------------------------
// bnfa_dp: allocator datapath
// Config registers, free map RAM, dividers, word scan and result register.
// ----------------------------------------------------------------------------
module bnfa_dp #(
    parameter int NUM_BLOCKS  = bnfa_pkg::DEF_NUM_BLOCKS,
    parameter int BLOCK_BYTES = bnfa_pkg::DEF_BLOCK_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bnfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bnfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_action,
    input  logic [bnfa_pkg::SIZE_W-1:0]   i_byte_size,
    input  logic [bnfa_pkg::OFFS_W-1:0]   i_byte_offset,
    output logic [1:0]                    o_status,
    output logic [bnfa_pkg::OFFS_W-1:0]   o_granted_offset,
    output logic [bnfa_pkg::SIZE_W-1:0]   o_granted_bytes,
    input  bnfa_pkg::t_dp_cmd             i_cmd,
    output bnfa_pkg::t_dp_sts             o_sts
);
    import bnfa_pkg::*;

    localparam int BIDX_W    = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = BIDX_W + 1;
    localparam int IW        = (CNT_W > DIV_W) ? CNT_W : DIV_W;
    localparam int PTR_W     = (BIDX_W > FB_W) ? BIDX_W : FB_W;
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BB_W      = $clog2(BLOCK_BYTES + 1);
    localparam int PW        = IW + BB_W;

    // config and persistent state
    logic [BC_W-1:0]  r_block_count;
    logic [FB_W-1:0]  r_first_block;
    logic [PTR_W-1:0] r_ptr;
    logic [WA_W-1:0]  r_clr_cnt;

    // per-request working registers
    logic                 r_action;
    logic [SIZE_W-1:0]    r_size;
    logic [IW-1:0]        r_need, r_w, r_start, r_run, r_lo, r_hi;
    logic                 r_pass, r_set;
    t_status              r_status;
    logic [1:0]           r_out_status;
    logic [OFFS_W-1:0]    r_out_offset;
    logic [SIZE_W-1:0]    r_out_bytes;

    logic [DIV_W-1:0]     w_q_size, w_q_addr;
    logic                 w_done_size, w_done_addr;
    logic [IW-1:0]        w_lim, w_bc, w_first, w_need_q, w_aq, w_sum, w_hi_free;
    logic [IW-1:0]        w_run_n, w_at, w_end;
    logic                 w_found;
    logic [WORD_BITS-1:0] w_rdata, w_mask, w_wdata;
    logic [WA_W-1:0]      w_addr;
    logic                 w_we;
    logic [PW-1:0]        w_bprod, w_gprod;

    // size rounded up, and offset to block index
    bnfa_div #(.DW(DIV_W), .DIVISOR(BLOCK_BYTES)) u_div_size (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend (DIV_W'(i_byte_size) + DIV_W'(BLOCK_BYTES - 1)),
        .o_quotient (w_q_size),
        .o_done     (w_done_size)
    );

    bnfa_div #(.DW(DIV_W), .DIVISOR(BLOCK_BYTES)) u_div_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend (DIV_W'(i_byte_offset)),
        .o_quotient (w_q_addr),
        .o_done     (w_done_addr)
    );

    assign w_addr  = i_cmd.clr ? r_clr_cnt : r_w[WA_W-1:0];
    assign w_we    = i_cmd.clr || i_cmd.mwrite;
    assign w_wdata = i_cmd.clr ? '0 : (r_set ? (w_rdata | w_mask) : (w_rdata & ~w_mask));

    bnfa_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS), .AW(WA_W)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_bc      = IW'(r_block_count);
    assign w_lim     = (w_bc < IW'(NUM_BLOCKS)) ? w_bc : IW'(NUM_BLOCKS);
    assign w_first   = IW'(r_first_block);
    assign w_need_q  = IW'(w_q_size);
    assign w_aq      = IW'(w_q_addr);
    assign w_sum     = w_aq + w_need_q;
    assign w_hi_free = (w_sum > w_lim) ? w_lim : w_sum;
    assign w_end     = w_at + r_need;

    // scan one word: run length carries across words
    always_comb begin
        logic [IW-1:0] gi;
        w_run_n = r_run;
        w_found = 1'b0;
        w_at    = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            gi = (r_w << WB_LOG) | IW'(b);
            if (!w_found && gi >= r_start && gi < w_lim) begin
                if (w_rdata[b]) begin
                    w_run_n = '0;
                end else begin
                    w_run_n = w_run_n + 1'b1;
                    if (w_run_n == r_need) begin
                        w_found = 1'b1;
                        w_at    = gi + 1'b1 - r_need;
                    end
                end
            end
        end
    end

    always_comb begin
        logic [IW-1:0] gi;
        for (int b = 0; b < WORD_BITS; b++) begin
            gi        = (r_w << WB_LOG) | IW'(b);
            w_mask[b] = (gi >= r_lo) && (gi < r_hi);
        end
    end

    assign w_bprod = PW'(r_need) * PW'(BLOCK_BYTES);
    assign w_gprod = PW'(r_lo) * PW'(BLOCK_BYTES);

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = (r_clr_cnt == WA_W'(NUM_WORDS - 1));
        o_sts.div_done  = w_done_size && w_done_addr;
        o_sts.go_search = (r_action == ACT_ALLOC) && (r_size != '0) && (w_need_q <= w_lim);
        o_sts.go_modify = (r_action == ACT_FREE) && (w_aq < w_lim) && (w_need_q != '0);
        o_sts.past_end  = (r_w << WB_LOG) >= w_lim;
        o_sts.pass2     = r_pass;
        o_sts.found     = w_found;
        o_sts.m_last    = ((r_w + 1'b1) << WB_LOG) >= r_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BC_RESET;
            r_first_block <= '0;
            r_ptr         <= '0;
            r_clr_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BC_W-1:0];
                    CFG_FIRST_BLOCK: r_first_block <= i_cfg_data[FB_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.decide && r_action == ACT_ALLOC && r_size != '0 && w_need_q > w_lim) begin
                r_ptr <= PTR_W'(r_first_block);
            end
            if (i_cmd.fail) begin
                r_ptr <= PTR_W'(r_first_block);
            end
            if (i_cmd.eval && w_found) begin
                r_ptr <= (w_end >= w_lim) ? PTR_W'(r_first_block) : PTR_W'(w_end);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_size   <= i_byte_size;
        end
        if (i_cmd.decide) begin
            r_need   <= w_need_q;
            r_status <= ST_OK;
            r_run    <= '0;
            r_pass   <= 1'b0;
            r_set    <= (r_action == ACT_ALLOC);
            if (r_action == ACT_ALLOC) begin
                r_start <= IW'(r_ptr);
                r_w     <= IW'(r_ptr) >> WB_LOG;
                if (r_size == '0)           r_status <= ST_ZERO;
                else if (w_need_q > w_lim)  r_status <= ST_NO_SPACE;
            end else begin
                r_lo <= w_aq;
                r_hi <= w_hi_free;
                r_w  <= w_aq >> WB_LOG;
                if (w_aq >= w_lim) r_status <= ST_BAD_FREE;
            end
        end
        if (i_cmd.restart) begin
            r_pass  <= 1'b1;
            r_start <= w_first;
            r_run   <= '0;
            r_w     <= w_first >> WB_LOG;
        end
        if (i_cmd.fail) begin
            r_status <= ST_NO_SPACE;
        end
        if (i_cmd.eval) begin
            if (w_found) begin
                r_lo <= w_at;
                r_hi <= w_end;
                r_w  <= w_at >> WB_LOG;
            end else begin
                r_run <= w_run_n;
                r_w   <= r_w + 1'b1;
            end
        end
        if (i_cmd.mwrite) begin
            r_w <= r_w + 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            r_out_offset <= (r_action == ACT_ALLOC && r_status == ST_OK)
                            ? w_gprod[OFFS_W-1:0] : '0;
            r_out_bytes  <= (w_bprod > PW'(BYTES_MAX)) ? BYTES_MAX : w_bprod[SIZE_W-1:0];
        end
    end

    assign o_status         = r_out_status;
    assign o_granted_offset = r_out_offset;
    assign o_granted_bytes  = r_out_bytes;
endmodule

// ===== hw/rtl/bitmap_next_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_next_fit_block_allocator: next-fit contiguous block allocator
// Free map of one bit per block with a next-fit pointer; allocate and free.
// ----------------------------------------------------------------------------
// After reset the block clears the free map word by word and takes no
// request meanwhile; config writes are taken at any time but should only
// change while no request is in flight. Requests are handled one at a
// time. Each beat is accepted, passes the size/offset dividers (reciprocal
// multiply) and a decision step; the search reads and evaluates one map
// word (8 blocks) at a time, restarts from first_block when it runs past
// the end and gives up at the end of that second pass; setting or clearing
// a run reads and writes back each map word it touches; then the result
// register is loaded and the result beat is offered the cycle after.
// The map RAM's single port (one read or one write per cycle) sets the scan
// and update cost. A new request is accepted only once the previous result
// has been taken, at the earliest in the same cycle as that result beat.
// ----------------------------------------------------------------------------
module bitmap_next_fit_block_allocator #(
    parameter int NUM_BLOCKS  = bnfa_pkg::DEF_NUM_BLOCKS,
    parameter int BLOCK_BYTES = bnfa_pkg::DEF_BLOCK_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bnfa_req_if.sink                        i_req,
    bnfa_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [bnfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bnfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bnfa_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // state machine: beat handshakes and sequencing
    bnfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // map, dividers, search and result register
    bnfa_dp #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_req.action),
        .i_byte_size      (i_req.byte_size),
        .i_byte_offset    (i_req.byte_offset),
        .o_status         (o_rsp.status),
        .o_granted_offset (o_rsp.granted_offset),
        .o_granted_bytes  (o_rsp.granted_bytes),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts)
    );
endmodule

// ===== hw/rtl/bnfa_chk.sv =====
// ----------------------------------------------------------------------------
// bnfa_chk: port checker
// Assertions on the allocator's ports, bound to the top level.
// ----------------------------------------------------------------------------
module bnfa_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [1:0]                  i_status,
    input logic [bnfa_pkg::OFFS_W-1:0] i_granted_offset,
    input logic [bnfa_pkg::SIZE_W-1:0] i_granted_bytes
);
    import bnfa_pkg::*;

    // no result survives reset
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // a request is only taken when the result slot frees up
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_ready && i_rsp_valid) |-> i_rsp_ready)
        else $error("request accepted over pending result");

    // only a successful allocation carries an offset
    a_offset_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_granted_offset != '0) |-> (i_status == ST_OK))
        else $error("offset with error status");

    // zero-size request rounds to zero bytes
    a_zero_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == ST_ZERO) |-> (i_granted_bytes == '0))
        else $error("zero-size result with nonzero length");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_status) && $stable(i_granted_offset)
         && $stable(i_granted_bytes)))
        else $error("stalled result changed");
endmodule

bind bitmap_next_fit_block_allocator bnfa_chk u_bnfa_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_granted_offset (o_rsp.granted_offset),
    .i_granted_bytes  (o_rsp.granted_bytes)
);
